@@ rtl/thfe_pkg.sv @@
// Package: shared constants, types and a decode helper of the tar header field extractor.
`default_nettype none

package thfe_pkg;

  // Block geometry
  localparam int unsigned BlockLen   = 512;
  localparam int unsigned PosW       = $clog2(BlockLen);
  localparam int unsigned NumFields  = 5;

  // Field order inside the stop vector
  localparam int unsigned FldMode = 0;
  localparam int unsigned FldUid  = 1;
  localparam int unsigned FldGid  = 2;
  localparam int unsigned FldSize = 3;
  localparam int unsigned FldTime = 4;

  localparam logic [PosW-1:0] FieldStart [NumFields] = '{
    PosW'(100), PosW'(108), PosW'(116), PosW'(124), PosW'(136)
  };
  localparam logic [PosW-1:0] FieldEnd [NumFields] = '{
    PosW'(108), PosW'(116), PosW'(124), PosW'(136), PosW'(148)
  };

  localparam logic [PosW-1:0] TypeflagPos = PosW'(156);
  localparam logic [PosW-1:0] LastPos     = PosW'(BlockLen - 1);

  // Payload widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdW    = 24;
  localparam int unsigned LongW  = 36;
  localparam int unsigned KindW  = 3;

  // ASCII codes
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChOne   = 8'h31;
  localparam logic [ByteW-1:0] ChThree = 8'h33;
  localparam logic [ByteW-1:0] ChFour  = 8'h34;
  localparam logic [ByteW-1:0] ChFive  = 8'h35;
  localparam logic [ByteW-1:0] ChSix   = 8'h36;
  localparam logic [ByteW-1:0] ChSeven = 8'h37;

  typedef enum logic [KindW-1:0] {
    KIND_REGULAR = 3'd0,
    KIND_LINK    = 3'd1,
    KIND_CHAR    = 3'd2,
    KIND_BLOCK   = 3'd3,
    KIND_DIR     = 3'd4,
    KIND_FIFO    = 3'd5
  } file_kind_e;

  typedef struct packed {
    logic [IdW-1:0]   file_mode;
    logic [IdW-1:0]   owner_id;
    logic [IdW-1:0]   group_id;
    logic [LongW-1:0] file_size;
    logic [LongW-1:0] mod_time;
    logic [KindW-1:0] file_kind;
  } hdr_result_t;

  // Map the type flag byte to a file kind
  function automatic file_kind_e decode_kind(logic [ByteW-1:0] b);
    file_kind_e k;
    case (b)
      ChOne:   k = KIND_LINK;
      ChThree: k = KIND_CHAR;
      ChFour:  k = KIND_BLOCK;
      ChFive:  k = KIND_DIR;
      ChSix:   k = KIND_FIFO;
      default: k = KIND_REGULAR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/thfe_if.sv @@
// Interfaces: header byte channel and result channel with valid/ready handshake.
`default_nettype none

interface thfe_hdr_if;
  logic       valid;
  logic       ready;
  logic [7:0] hdr_byte;

  modport source (output valid, output hdr_byte, input ready);
  modport sink   (input valid, input hdr_byte, output ready);
endinterface

interface thfe_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] file_mode;
  logic [23:0] owner_id;
  logic [23:0] group_id;
  logic [35:0] file_size;
  logic [35:0] mod_time;
  logic [2:0]  file_kind;

  modport source (output valid, output file_mode, output owner_id, output group_id,
                  output file_size, output mod_time, output file_kind, input ready);
  modport sink   (input valid, input file_mode, input owner_id, input group_id,
                  input file_size, input mod_time, input file_kind, output ready);
endinterface

`default_nettype wire

@@ rtl/tar_header_field_extractor_unit.sv @@
// Top level: tar header field extractor with input register, parser and result register.
//
//   channel   dir   payload                                                  handshake
//   hdr_i     in    hdr_byte[7:0]                                             valid/ready
//   res_o     out   file_mode[23:0] owner_id[23:0] group_id[23:0]             valid/ready
//                   file_size[35:0] mod_time[35:0] file_kind[2:0]
//
// One byte is taken per cycle unless the last byte of a block waits on a full result
// register; the 512th byte passes the input register, then loads result and valid registers.
// Reset clears the byte position, accumulators, stop bits and both valid flags.
// Only the last byte of a block waits on a full result register; all other bytes keep
// flowing while a result waits to be taken.
`default_nettype none

module tar_header_field_extractor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  thfe_hdr_if.sink   hdr_i,
  thfe_res_if.source res_o
);
  import thfe_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             res_valid_q, res_valid_d;
  hdr_result_t      res_q;
  hdr_result_t      parse_res;
  logic             parse_last;
  logic             res_free;
  logic             step;

  // Advance the input register unless its last byte meets a full result register
  assign res_free    = !res_valid_q || res_o.ready;
  assign step        = in_valid_q && (!parse_last || res_free);
  assign hdr_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (hdr_i.ready) begin
      in_valid_q <= hdr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_i.ready && hdr_i.valid) begin
      in_byte_q <= hdr_i.hdr_byte;
    end
  end

  thfe_field_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .last_o   (parse_last),
    .result_o (parse_res)
  );

  // Load the result register on the last byte, drop it when taken
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_o.ready) res_valid_d = 1'b0;
    if (step && parse_last) res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && parse_last) begin
      res_q <= parse_res;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.file_mode = res_q.file_mode;
  assign res_o.owner_id  = res_q.owner_id;
  assign res_o.group_id  = res_q.group_id;
  assign res_o.file_size = res_q.file_size;
  assign res_o.mod_time  = res_q.mod_time;
  assign res_o.file_kind = res_q.file_kind;

  // A taken last byte always yields a result in the next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && parse_last |=> res_valid_q)
    else $error("last byte of block did not load a result");

  // Bytes other than the last never stall the input
  a_mid_block_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !parse_last |-> hdr_i.ready)
    else $error("input stalled on a mid-block byte");

  // A waiting result is not overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |-> !(step && parse_last))
    else $error("result overwritten while waiting");

endmodule

`default_nettype wire

@@ rtl/thfe_field_parser.sv @@
// Field parser: byte position counter, octal accumulators, stop bits and type flag decode.
`default_nettype none

module thfe_field_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [thfe_pkg::ByteW-1:0] byte_i,
  output logic                       last_o,
  output thfe_pkg::hdr_result_t      result_o
);
  import thfe_pkg::*;

  logic [PosW-1:0]      pos_q, pos_d;
  logic [IdW-1:0]       mode_q, mode_d, uid_q, uid_d, gid_q, gid_d;
  logic [LongW-1:0]     size_q, size_d, time_q, time_d;
  logic [NumFields-1:0] stop_q, stop_d;
  file_kind_e           kind_q, kind_d;

  logic [NumFields-1:0] live;
  logic                 is_digit;
  logic [2:0]           digit;

  // Classify the byte and find the field that the position falls in
  always_comb begin
    is_digit = (byte_i >= ChZero) && (byte_i <= ChSeven);
    digit    = 3'(byte_i - ChZero);
    for (int f = 0; f < NumFields; f++) begin
      live[f] = (pos_q >= FieldStart[f]) && (pos_q < FieldEnd[f]) && !stop_q[f];
    end
  end

  assign last_o = (pos_q == LastPos);

  // Shift a digit into the live field, or stop it
  always_comb begin
    pos_d  = pos_q;
    mode_d = mode_q;
    uid_d  = uid_q;
    gid_d  = gid_q;
    size_d = size_q;
    time_d = time_q;
    stop_d = stop_q;
    kind_d = kind_q;
    if (step_i) begin
      pos_d = pos_q + PosW'(1);
      if (is_digit) begin
        if (live[FldMode]) mode_d = {mode_q[IdW-4:0], digit};
        if (live[FldUid])  uid_d  = {uid_q[IdW-4:0], digit};
        if (live[FldGid])  gid_d  = {gid_q[IdW-4:0], digit};
        if (live[FldSize]) size_d = {size_q[LongW-4:0], digit};
        if (live[FldTime]) time_d = {time_q[LongW-4:0], digit};
      end else begin
        stop_d = stop_q | live;
      end
      if (pos_q == TypeflagPos) kind_d = decode_kind(byte_i);
      // Clear the block state once the last byte is taken
      if (last_o) begin
        pos_d  = '0;
        mode_d = '0;
        uid_d  = '0;
        gid_d  = '0;
        size_d = '0;
        time_d = '0;
        stop_d = '0;
        kind_d = KIND_REGULAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mode_q <= '0;
      uid_q  <= '0;
      gid_q  <= '0;
      size_q <= '0;
      time_q <= '0;
      stop_q <= '0;
      kind_q <= KIND_REGULAR;
    end else begin
      pos_q  <= pos_d;
      mode_q <= mode_d;
      uid_q  <= uid_d;
      gid_q  <= gid_d;
      size_q <= size_d;
      time_q <= time_d;
      stop_q <= stop_d;
      kind_q <= kind_d;
    end
  end

  // Present the finished values; the last byte lies outside every field
  always_comb begin
    result_o.file_mode = mode_q;
    result_o.owner_id  = uid_q;
    result_o.group_id  = gid_q;
    result_o.file_size = size_q;
    result_o.mod_time  = time_q;
    result_o.file_kind = kind_q;
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Testbench: streams ustar header blocks byte by byte and checks the parsed fields of each block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import thfe_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandBlocks  = 48;
  localparam int unsigned HoldCycles  = 1600;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;

  // Numeric fields of the header: first byte and length
  localparam int unsigned HdrFieldAt  [NumFields] = '{100, 108, 116, 124, 136};
  localparam int unsigned HdrFieldLen [NumFields] = '{8, 8, 8, 12, 12};

  // One directed header block: field texts, type flag, filler for every other byte
  typedef struct {
    string       txt [NumFields];
    logic [7:0]  tflag;
    logic [7:0]  fill;
    bit          typed;
    hdr_result_t want;
  } hdr_row_t;

  // What the checker should use for one block's result
  typedef struct {
    bit          typed;
    hdr_result_t want;
  } block_note_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  thfe_hdr_if hdr_if ();
  thfe_res_if res_if ();

  tar_header_field_extractor_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hdr_i  (hdr_if),
    .res_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser state mirrored from the block
  logic [PosW-1:0]      hdr_pos;
  logic [LongW-1:0]     field_acc [NumFields];
  logic [NumFields-1:0] field_done;
  file_kind_e           hdr_kind;

  logic [7:0]     hdr_blk [BlockLen];
  hdr_result_t    hdr_results_due [$];
  block_note_t    block_notes [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_reqs   = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned results_seen = 0;
  int unsigned blocks_sent = 0;
  int unsigned bytes_sent  = 0;

  function automatic hdr_result_t hdr_res(logic [IdW-1:0] mode, logic [IdW-1:0] uid,
                                          logic [IdW-1:0] gid, logic [LongW-1:0] size,
                                          logic [LongW-1:0] mtime, file_kind_e kind);
    hdr_result_t r;
    r.file_mode = mode;
    r.owner_id  = uid;
    r.group_id  = gid;
    r.file_size = size;
    r.mod_time  = mtime;
    r.file_kind = kind;
    return r;
  endfunction

  function automatic hdr_row_t hdr_row(string m, string u, string g, string s, string t,
                                       logic [7:0] tflag, logic [7:0] fill,
                                       bit typed, hdr_result_t want);
    hdr_row_t row;
    row.txt   = '{m, u, g, s, t};
    row.tflag = tflag;
    row.fill  = fill;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Clear the per-block accumulators, stop bits and kind
  function automatic void clear_hdr_state();
    int f;
    for (f = 0; f < NumFields; f++) field_acc[f] = '0;
    field_done = '0;
    hdr_kind   = KIND_REGULAR;
  endfunction

  function automatic file_kind_e kind_of_flag(logic [7:0] b);
    case (b)
      ChOne:   return KIND_LINK;
      ChThree: return KIND_CHAR;
      ChFour:  return KIND_BLOCK;
      ChFive:  return KIND_DIR;
      ChSix:   return KIND_FIFO;
      default: return KIND_REGULAR;
    endcase
  endfunction

  // Advance the parser by one byte; return 1 with the block's fields after its last byte
  function automatic bit parse_hdr_byte(input logic [7:0] b, output hdr_result_t res);
    int f;
    int unsigned p;
    logic [LongW-1:0] mask;
    res = '0;
    p   = hdr_pos;
    for (f = 0; f < NumFields; f++) begin
      mask = (f <= FldGid) ? LongW'({IdW{1'b1}}) : {LongW{1'b1}};
      if (p >= HdrFieldAt[f] && p < HdrFieldAt[f] + HdrFieldLen[f] && !field_done[f]) begin
        if (b >= ChZero && b <= ChSeven) begin
          field_acc[f] = ((field_acc[f] << 3) | LongW'(b - ChZero)) & mask;
        end else begin
          field_done[f] = 1'b1;
        end
      end
    end
    if (p == TypeflagPos) hdr_kind = kind_of_flag(b);
    if (p == LastPos) begin
      res = hdr_res(field_acc[FldMode][IdW-1:0], field_acc[FldUid][IdW-1:0],
                    field_acc[FldGid][IdW-1:0], field_acc[FldSize], field_acc[FldTime],
                    hdr_kind);
      hdr_pos = '0;
      clear_hdr_state();
      return 1'b1;
    end
    hdr_pos = hdr_pos + 1'b1;
    return 1'b0;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("MISMATCH @%0d: %s", cycle_count, msg);
  endfunction

  function automatic void cmp_field(string name, logic [LongW-1:0] want,
                                    logic [LongW-1:0] got);
    if (got !== want) note_mismatch($sformatf("%s expected %h, got %h", name, want, got));
  endfunction

  // Offer one byte, with random gaps, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      hdr_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    hdr_if.valid    <= 1'b1;
    hdr_if.hdr_byte <= b;
    do @(posedge clk_i); while (!hdr_if.ready);
    bytes_sent++;
  endtask

  task automatic send_block(input bit typed, input hdr_result_t want);
    int unsigned i;
    block_notes.push_back('{typed: typed, want: want});
    for (i = 0; i < BlockLen; i++) send_byte(hdr_blk[i]);
    blocks_sent++;
  endtask

  // Drop valid and hold until every expected result has been taken
  task automatic wait_drained();
    hdr_if.valid <= 1'b0;
    @(posedge clk_i);
    while (hdr_results_due.size() != 0) @(posedge clk_i);
  endtask

  // Track accepted bytes and queue the fields due at each block end
  always @(posedge clk_i) begin : watch_hdr
    hdr_result_t res;
    block_note_t note;
    bit          done;
    if (rst_ni && hdr_if.valid && hdr_if.ready) begin
      done = parse_hdr_byte(hdr_if.hdr_byte, res);
      if (done) begin
        note = block_notes.pop_front();
        hdr_results_due.push_back(note.typed ? note.want : res);
      end
    end
  end

  // Compare each taken result with the oldest one due
  always @(posedge clk_i) begin : check_res
    hdr_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (hdr_results_due.size() == 0) begin
        note_mismatch("result with no header block pending");
      end else begin
        want = hdr_results_due.pop_front();
        cmp_field("file_mode", want.file_mode, res_if.file_mode);
        cmp_field("owner_id",  want.owner_id,  res_if.owner_id);
        cmp_field("group_id",  want.group_id,  res_if.group_id);
        cmp_field("file_size", want.file_size, res_if.file_size);
        cmp_field("mod_time",  want.mod_time,  res_if.mod_time);
        cmp_field("file_kind", want.file_kind, res_if.file_kind);
      end
    end
  end

  // Drive result ready: random stalls, or a long hold-off on request
  initial begin : drive_res_ready
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still due",
               cycle_count, hdr_results_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : run_stimulus
    hdr_row_t    rows [$];
    int unsigned r, f, i, n, ph;
    logic [7:0]  nb;

    rst_ni          <= 1'b0;
    hdr_if.valid    <= 1'b0;
    hdr_if.hdr_byte <= '0;
    hdr_pos = '0;
    clear_hdr_state();

    // Directed blocks: extremes, every kind, non-octal starts, unterminated fields
    rows.push_back(hdr_row("", "", "", "", "", 8'h00, 8'h00, 1'b1,
                           hdr_res('0, '0, '0, '0, '0, KIND_REGULAR)));
    rows.push_back(hdr_row("", "", "", "", "", ChFive, ChSeven, 1'b1,
                           hdr_res('1, '1, '1, '1, '1, KIND_DIR)));
    rows.push_back(hdr_row("", "", "", "", "", ChOne, 8'hFF, 1'b1,
                           hdr_res('0, '0, '0, '0, '0, KIND_LINK)));
    rows.push_back(hdr_row("0000755", "17", "", "", "", ChFour, 8'h00, 1'b1,
                           hdr_res(24'o755, 24'o17, '0, '0, '0, KIND_BLOCK)));
    rows.push_back(hdr_row("", "", "", "", "", "L", "A", 1'b1,
                           hdr_res('0, '0, '0, '0, '0, KIND_REGULAR)));
    rows.push_back(hdr_row("0000644", "0001750", "0001750", "00000012345", "14621234567",
                           ChZero, 8'h00, 1'b0, '0));
    rows.push_back(hdr_row(" 755", "  1000", "0x1F", "777", "12345670123",
                           ChThree, " ", 1'b0, '0));
    rows.push_back(hdr_row("", "", "", "", "", ChFour, ChOne, 1'b0, '0));
    rows.push_back(hdr_row("89", "0089", "12-3", "7777777777778", "", ChSix, 8'h80,
                           1'b0, '0));
    rows.push_back(hdr_row("7777777", "", "", "777777777777", "77777777777", "2", ChZero,
                           1'b0, '0));
    rows.push_back(hdr_row("1234567", "7654321", "0", "1", "7", 8'hFF, ChThree, 1'b0, '0));

    tx_idle_pct = 37;
    rx_idle_pct = 88;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      for (i = 0; i < BlockLen; i++) hdr_blk[i] = rows[r].fill;
      for (f = 0; f < NumFields; f++) begin
        for (i = 0; i < rows[r].txt[f].len() && i < HdrFieldLen[f]; i++) begin
          hdr_blk[HdrFieldAt[f] + i] = rows[r].txt[f][i];
        end
      end
      hdr_blk[TypeflagPos] = rows[r].tflag;
      send_block(rows[r].typed, rows[r].want);
    end
    wait_drained();

    // Random blocks in three idle mixes; the last one opens with a long result hold-off
    for (ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 88 : 0;
      rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 37 : 0;
      if (ph == 2) hold_reqs++;
      for (r = 0; r < RandBlocks / 3; r++) begin
        for (i = 0; i < BlockLen; i++) hdr_blk[i] = 8'($urandom_range(255));
        // Mostly octal digits with a terminator; some fields full length or pure noise
        for (f = 0; f < NumFields; f++) begin
          n = $urandom_range(9);
          if (n != 0) begin
            n = (n == 1) ? HdrFieldLen[f] : $urandom_range(HdrFieldLen[f] - 1);
            for (i = 0; i < n; i++) begin
              hdr_blk[HdrFieldAt[f] + i] = ChZero + 8'($urandom_range(7));
            end
            if (n < HdrFieldLen[f]) begin
              case ($urandom_range(2))
                0:       nb = 8'h00;
                1:       nb = " ";
                default: begin
                  do nb = 8'($urandom_range(255)); while (nb >= ChZero && nb <= ChSeven);
                end
              endcase
              hdr_blk[HdrFieldAt[f] + n] = nb;
            end
          end
        end
        case ($urandom_range(9))
          0:       hdr_blk[TypeflagPos] = ChZero;
          1:       hdr_blk[TypeflagPos] = ChOne;
          2:       hdr_blk[TypeflagPos] = ChThree;
          3:       hdr_blk[TypeflagPos] = ChFour;
          4:       hdr_blk[TypeflagPos] = ChFive;
          5:       hdr_blk[TypeflagPos] = ChSix;
          6:       hdr_blk[TypeflagPos] = 8'h00;
          7:       hdr_blk[TypeflagPos] = "2";
          default: ;
        endcase
        send_block(1'b0, '0);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d header blocks (%0d bytes) and checked %0d results in %0d cycles.",
             blocks_sent, bytes_sent, results_seen, cycle_count);
    $display("Idle mixes 37/88, 88/37 and none, plus a %0d-cycle result hold-off; %0d mismatches.",
             HoldCycles, mismatches);
    if (mismatches == 0 && hdr_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
